@@ sv/vertex_project_to_window_core_assert.svh @@
// Assertion macros for the vertex projection block.
// Used by files that check their own logic; depends on a clk and arst_n in scope.
`ifndef VERTEX_PROJECT_TO_WINDOW_CORE_ASSERT_SVH
`define VERTEX_PROJECT_TO_WINDOW_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define PVW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define PVW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ sv/pvw_pkg.sv @@
// Shared types, constants and saturation functions of the vertex projection block.
// Has no dependencies; every module file imports it.
`timescale 1ns / 1ps

package pvw_pkg;

	localparam int CW = 32;
	localparam int FRAC = 16;
	localparam int CF = 12;
	localparam int PW = CW + 16;
	localparam int SW = PW + 2;
	localparam int CLW = SW - CF;
	localparam int VW = CW + 34;
	localparam int LATENCY = CW + 6;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
	} clip_t;

	typedef enum logic [2:0] {
		REG_ROW0,
		REG_ROW1,
		REG_ROW2,
		REG_ROW3,
		REG_ORIGIN,
		REG_SIZE
	} reg_idx_t;

	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

	function automatic coord_t sat_clip(input logic signed [CLW-1:0] v);
		coord_t r;
		if (v > CLW'(CMAX)) r = CMAX;
		else if (v < CLW'(CMIN)) r = CMIN;
		else r = coord_t'(v);
		return r;
	endfunction

	function automatic coord_t sat_vp(input logic signed [VW-1:0] v);
		coord_t r;
		if (v > VW'(CMAX)) r = CMAX;
		else if (v < VW'(CMIN)) r = CMIN;
		else r = coord_t'(v);
		return r;
	endfunction

endpackage

@@ sv/pvw_matmul.sv @@
// Matrix stage: sixteen coefficient products, then row sums floored and saturated.
// Depends on pvw_pkg.
`timescale 1ns / 1ps

module pvw_matmul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  pvw_pkg::clip_t           vin,
	input  logic [3:0][63:0]         rows,
	output logic                     out_valid,
	output pvw_pkg::clip_t           clip
);
	import pvw_pkg::*;

	coord_t v [4];
	logic signed [PW-1:0] prod_s1 [4][4];
	logic valid_s1;
	coord_t cl [4];

	assign v[0] = vin.x;
	assign v[1] = vin.y;
	assign v[2] = vin.z;
	assign v[3] = vin.w;

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[r][c] <= PW'($signed(rows[r][16*c +: 16])) * PW'(v[c]);
			end
		end
	end

	always_comb begin
		logic signed [SW-1:0] sum;
		for (int r = 0; r < 4; r++) begin
			sum = SW'(prod_s1[r][0]) + SW'(prod_s1[r][1]) + SW'(prod_s1[r][2])
				+ SW'(prod_s1[r][3]);
			cl[r] = sat_clip(sum[SW-1:CF]);
		end
	end

	always_ff @(posedge clk) begin
		clip <= '{x: cl[0], y: cl[1], z: cl[2], w: cl[3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			out_valid <= valid_s1;
		end
	end

endmodule

@@ sv/pvw_div.sv @@
// Pipelined restoring divider: three quotients by clip w, one bit per stage.
// Depends on pvw_pkg.
`timescale 1ns / 1ps

module pvw_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  pvw_pkg::clip_t               in_clip,
	output logic                         out_valid,
	output pvw_pkg::clip_t               out_clip,
	output logic [2:0][pvw_pkg::CW-1:0]  quot,
	output logic [2:0]                   ovf
);
	import pvw_pkg::*;

	typedef struct packed {
		logic [CW-1:0] rem;
		logic [CW-1:0] bits;
		logic [CW-1:0] q;
	} lane_t;

	lane_t [2:0]   lane_s  [0:CW];
	logic [CW-1:0] den_s   [0:CW];
	clip_t         clip_s  [0:CW];
	logic [2:0]    ovf_s   [0:CW];
	logic          valid_s [0:CW];

	always_ff @(posedge clk) begin
		coord_t c [3];
		logic [CW-1:0] a;
		logic [CW-1:0] d;
		c[0] = in_clip.x;
		c[1] = in_clip.y;
		c[2] = in_clip.z;
		d = in_clip.w[CW-1] ? CW'(-in_clip.w) : CW'(in_clip.w);
		for (int i = 0; i < 3; i++) begin
			a = c[i][CW-1] ? CW'(-c[i]) : CW'(c[i]);
			lane_s[0][i].rem <= a >> (CW - FRAC);
			lane_s[0][i].bits <= {a[CW-FRAC-1:0], {FRAC{1'b0}}};
			lane_s[0][i].q <= '0;
			ovf_s[0][i] <= (a >> (CW - FRAC)) >= d;
		end
		den_s[0] <= d;
		clip_s[0] <= in_clip;
	end

	for (genvar k = 0; k < CW; k++) begin : g_step
		always_ff @(posedge clk) begin
			logic [CW:0] trial;
			logic ge;
			for (int i = 0; i < 3; i++) begin
				trial = {lane_s[k][i].rem, lane_s[k][i].bits[CW-1]};
				ge = trial >= {1'b0, den_s[k]};
				lane_s[k+1][i].rem <= ge ? CW'(trial - {1'b0, den_s[k]}) : CW'(trial);
				lane_s[k+1][i].bits <= lane_s[k][i].bits << 1;
				lane_s[k+1][i].q <= {lane_s[k][i].q[CW-2:0], ge};
			end
			den_s[k+1] <= den_s[k];
			clip_s[k+1] <= clip_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CW; k++) valid_s[k] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
			for (int k = 0; k < CW; k++) valid_s[k+1] <= valid_s[k];
		end
	end

	assign out_valid = valid_s[CW];
	assign out_clip = clip_s[CW];
	assign ovf = ovf_s[CW];
	always_comb begin
		for (int i = 0; i < 3; i++) quot[i] = lane_s[CW][i].q;
	end

endmodule

@@ sv/pvw_view.sv @@
// Range mapping and viewport scale and offset, in three register stages.
// Depends on pvw_pkg.
`timescale 1ns / 1ps

module pvw_view (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  pvw_pkg::clip_t               clip,
	input  logic [2:0][pvw_pkg::CW-1:0]  quot,
	input  logic [2:0]                   ovf,
	input  logic [63:0]                  origin,
	input  logic [63:0]                  size,
	output logic                         done,
	output pvw_pkg::coord_t              win_x,
	output pvw_pkg::coord_t              win_y,
	output pvw_pkg::coord_t              win_depth,
	output pvw_pkg::coord_t              clip_w,
	output logic                         ok
);
	import pvw_pkg::*;

	localparam logic [CW-1:0] QPOS = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] QNEG = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW:0] ONE_Q = (CW+1)'(1) <<< FRAC;

	coord_t m_s1 [3];
	clip_t  clip_s1, clip_s2;
	logic   ok_s1, ok_s2;
	logic   valid_s1, valid_s2;
	logic [CW+31:0] prod_s2 [2];
	logic   neg_s2 [2];
	coord_t depth_s2;

	always_ff @(posedge clk) begin
		coord_t c [3];
		coord_t n;
		logic neg;
		logic signed [CW:0] t;
		c[0] = clip.x;
		c[1] = clip.y;
		c[2] = clip.z;
		for (int i = 0; i < 3; i++) begin
			neg = c[i][CW-1] ^ clip.w[CW-1];
			if (!neg) n = (ovf[i] || quot[i] > QPOS) ? CMAX : coord_t'(quot[i]);
			else n = (ovf[i] || quot[i] > QNEG) ? CMIN : -coord_t'(quot[i]);
			t = {n[CW-1], n} + ONE_Q;
			m_s1[i] <= t[CW:1];
		end
		clip_s1 <= clip;
		ok_s1 <= clip.w != '0;
	end

	always_ff @(posedge clk) begin
		logic [CW-1:0] am;
		for (int i = 0; i < 2; i++) begin
			am = m_s1[i][CW-1] ? CW'(-m_s1[i]) : CW'(m_s1[i]);
			prod_s2[i] <= (CW+32)'(am) * (CW+32)'(size[32*i +: 32]);
			neg_s2[i] <= m_s1[i][CW-1];
		end
		depth_s2 <= m_s1[2];
		clip_s2 <= clip_s1;
		ok_s2 <= ok_s1;
	end

	always_ff @(posedge clk) begin
		logic signed [VW-1:0] s;
		coord_t r [2];
		for (int i = 0; i < 2; i++) begin
			s = $signed({2'b00, prod_s2[i]});
			if (neg_s2[i]) s = -s;
			s = s + (VW'($signed(origin[32*i +: 32])) <<< FRAC);
			r[i] = sat_vp(s);
		end
		win_x <= ok_s2 ? r[0] : clip_s2.x;
		win_y <= ok_s2 ? r[1] : clip_s2.y;
		win_depth <= ok_s2 ? depth_s2 : clip_s2.z;
		clip_w <= clip_s2.w;
		ok <= ok_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			done <= valid_s2;
		end
	end

endmodule

@@ sv/vertex_project_to_window_core.sv @@
// Top level of the vertex projection block: configuration registers and the pipeline.
// Depends on pvw_pkg, pvw_matmul, pvw_div, pvw_view and the assertion macro header.
//
// An item is one homogeneous vertex in signed Q16.16, accepted at a clock edge where
// start is high and busy is low. Busy is always low, so a new item may be given every
// cycle and the sustained rate is one item per cycle.
// Each item yields one result, shown for exactly one cycle with done high. Its path
// runs through two matrix stages, one divider setup stage, the divider, which
// resolves one quotient bit per stage for 32 stages, and three viewport stages.
// Results leave in the order items came in; the receiver cannot hold them off.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must do so only while
// no item is in flight, as the block does not enforce it. Indexes beyond the viewport size are ignored.
// Reset loads the identity matrix, a zero origin and a 640 by 480 viewport, and
// empties the pipeline at once, so no done strobe follows reset until an item enters.
`timescale 1ns / 1ps

module vertex_project_to_window_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pvw_pkg::coord_t  vert_x,
	input  pvw_pkg::coord_t  vert_y,
	input  pvw_pkg::coord_t  vert_z,
	input  pvw_pkg::coord_t  vert_w,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	output logic             done,
	output pvw_pkg::coord_t  win_x,
	output pvw_pkg::coord_t  win_y,
	output pvw_pkg::coord_t  win_depth,
	output pvw_pkg::coord_t  clip_w,
	output logic             ok
);
	import pvw_pkg::*;

	`include "vertex_project_to_window_core_assert.svh"

	logic [3:0][63:0] row_q;
	logic [63:0] origin_q;
	logic [63:0] size_q;
	logic mm_valid, dv_valid;
	clip_t mm_clip, dv_clip;
	logic [2:0][CW-1:0] dv_quot;
	logic [2:0] dv_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= 64'd4096;
			row_q[1] <= 64'd4096 << 16;
			row_q[2] <= 64'd4096 << 32;
			row_q[3] <= 64'd4096 << 48;
			origin_q <= '0;
			size_q <= (64'd480 << 32) | 64'd640;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROW0: row_q[0] <= cfg_data;
				REG_ROW1: row_q[1] <= cfg_data;
				REG_ROW2: row_q[2] <= cfg_data;
				REG_ROW3: row_q[3] <= cfg_data;
				REG_ORIGIN: origin_q <= cfg_data;
				REG_SIZE: size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	pvw_matmul u_matmul (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start && !busy),
		.vin('{x: vert_x, y: vert_y, z: vert_z, w: vert_w}),
		.rows(row_q),
		.out_valid(mm_valid),
		.clip(mm_clip)
	);

	pvw_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(mm_valid),
		.in_clip(mm_clip),
		.out_valid(dv_valid),
		.out_clip(dv_clip),
		.quot(dv_quot),
		.ovf(dv_ovf)
	);

	pvw_view u_view (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(dv_valid),
		.clip(dv_clip),
		.quot(dv_quot),
		.ovf(dv_ovf),
		.origin(origin_q),
		.size(size_q),
		.done(done),
		.win_x(win_x),
		.win_y(win_y),
		.win_depth(win_depth),
		.clip_w(clip_w),
		.ok(ok)
	);

	`PVW_ASSERT_IMP(a_ok_matches_w, done, ok == (clip_w != '0), "ok disagrees with clip w")
	`PVW_ASSERT_IMP(a_fixed_latency, done, $past(start, LATENCY), "result without an item")
	`PVW_ASSERT(a_never_busy, !busy, "busy raised")

endmodule
